### sv/btc_pkg.sv
// Shared types, constants and the CORDIC angle table for the balance tilt controller.
`default_nettype none

package btc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CIDX_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  // datapath widths
  localparam int XY_W   = 27;
  localparam int Z_W    = 28;
  localparam int PROD_W = 36;
  localparam int ACC_W  = 38;

  // configuration register indexes
  localparam logic [2:0] REG_PWM_OFFSET      = 3'd0;
  localparam logic [2:0] REG_SETPOINT_CENTER = 3'd1;
  localparam logic [2:0] REG_SETPOINT_SWING  = 3'd2;
  localparam logic [2:0] REG_SWITCH_LIMIT    = 3'd3;
  localparam logic [2:0] REG_ANGLE_GAIN      = 3'd4;
  localparam logic [2:0] REG_RATE_GAIN       = 3'd5;

  typedef struct packed {
    logic [11:0] pwm_offset;
    logic [12:0] setpoint_center;
    logic [11:0] setpoint_swing;
    logic [14:0] switch_limit;
    logic [15:0] angle_gain;
    logic [15:0] rate_gain;
    logic        center_wr;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE    = 3'd0,
    MUL_G_C01   = 3'd1,
    MUL_ACC_C02 = 3'd2,
    MUL_FUS_C08 = 3'd3,
    MUL_ERR_AG  = 3'd4,
    MUL_G_RG    = 3'd5
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD     = 2'd0,
    ACC_LD_FUSED = 2'd1,
    ACC_LD_PROD  = 2'd2,
    ACC_ADD_PROD = 2'd3
  } acc_op_t;

  typedef struct packed {
    logic     start;
    logic     cord_step;
    logic     angle_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     fuse_en;
    logic     target_en;
    logic     err_en;
    logic     drive_en;
  } dp_cmd_t;

  typedef struct packed {
    logic cord_last;
  } dp_sts_t;

  // atan(2^-i) in units of 1/(6000*4096) rad
  function automatic logic [24:0] atan_lut(input logic [4:0] idx);
    logic [24:0] v;
    case (idx)
      5'd0:  v = 25'd19301945;
      5'd1:  v = 25'd11394604;
      5'd2:  v = 25'd6020596;
      5'd3:  v = 25'd3056148;
      5'd4:  v = 25'd1534005;
      5'd5:  v = 25'd767750;
      5'd6:  v = 25'd383969;
      5'd7:  v = 25'd191996;
      5'd8:  v = 25'd96000;
      5'd9:  v = 25'd48000;
      5'd10: v = 25'd24000;
      5'd11: v = 25'd12000;
      5'd12: v = 25'd6000;
      5'd13: v = 25'd3000;
      5'd14: v = 25'd1500;
      5'd15: v = 25'd750;
      5'd16: v = 25'd375;
      5'd17: v = 25'd187;
      5'd18: v = 25'd94;
      5'd19: v = 25'd47;
      5'd20: v = 25'd23;
      5'd21: v = 25'd12;
      5'd22: v = 25'd6;
      5'd23: v = 25'd3;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### sv/btc_cfg.sv
// Configuration register file of the balance tilt controller.
`default_nettype none

module btc_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_wdata,
  output btc_pkg::cfg_t     cfg
);
  import btc_pkg::*;

  logic [11:0] offset_r, offset_nxt;
  logic [12:0] center_r, center_nxt;
  logic [11:0] swing_r, swing_nxt;
  logic [14:0] limit_r, limit_nxt;
  logic [15:0] again_r, again_nxt;
  logic [15:0] rgain_r, rgain_nxt;
  logic        center_wr_r, center_wr_nxt;

  always_comb begin
    offset_nxt = offset_r;
    center_nxt = center_r;
    swing_nxt  = swing_r;
    limit_nxt  = limit_r;
    again_nxt  = again_r;
    rgain_nxt  = rgain_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_PWM_OFFSET:      offset_nxt = cfg_wdata[11:0];
        REG_SETPOINT_CENTER: center_nxt = cfg_wdata[12:0];
        REG_SETPOINT_SWING:  swing_nxt  = cfg_wdata[11:0];
        REG_SWITCH_LIMIT:    limit_nxt  = cfg_wdata[14:0];
        REG_ANGLE_GAIN:      again_nxt  = cfg_wdata;
        REG_RATE_GAIN:       rgain_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  // load the setpoint in the cycle after the write, once center_r holds the new value
  assign center_wr_nxt = cfg_we && (cfg_index == REG_SETPOINT_CENTER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= 12'd360;
      center_r    <= 13'h1ED4;  // -300
      swing_r     <= 12'd800;
      limit_r     <= 15'd500;
      again_r     <= 16'd26214;
      rgain_r     <= 16'd36045;
      center_wr_r <= 1'b0;
    end else begin
      offset_r    <= offset_nxt;
      center_r    <= center_nxt;
      swing_r     <= swing_nxt;
      limit_r     <= limit_nxt;
      again_r     <= again_nxt;
      rgain_r     <= rgain_nxt;
      center_wr_r <= center_wr_nxt;
    end
  end

  always_comb begin
    cfg.pwm_offset      = offset_r;
    cfg.setpoint_center = center_r;
    cfg.setpoint_swing  = swing_r;
    cfg.switch_limit    = limit_r;
    cfg.angle_gain      = again_r;
    cfg.rate_gain       = rgain_r;
    cfg.center_wr       = center_wr_r;
  end

endmodule

`default_nettype wire

### sv/btc_ctrl.sv
// Sequencer of the balance tilt controller: frame handshake and datapath commands.
`default_nettype none

module btc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire btc_pkg::dp_sts_t sts,
  output btc_pkg::dp_cmd_t      cmd
);
  import btc_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_CORD  = 13'b0000000000010,
    ST_ANGLE = 13'b0000000000100,
    ST_A1    = 13'b0000000001000,
    ST_F1    = 13'b0000000010000,
    ST_A2    = 13'b0000000100000,
    ST_A3    = 13'b0000001000000,
    ST_F2    = 13'b0000010000000,
    ST_ERR   = 13'b0000100000000,
    ST_P4    = 13'b0001000000000,
    ST_A4    = 13'b0010000000000,
    ST_A5    = 13'b0100000000000,
    ST_DRV   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd.start     = 1'b0;
    cmd.cord_step = 1'b0;
    cmd.angle_en  = 1'b0;
    cmd.mul_sel   = MUL_NONE;
    cmd.acc_op    = ACC_HOLD;
    cmd.fuse_en   = 1'b0;
    cmd.target_en = 1'b0;
    cmd.err_en    = 1'b0;
    cmd.drive_en  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_CORD;
        end
      end
      ST_CORD: begin
        cmd.cord_step = 1'b1;
        if (sts.cord_last) state_nxt = ST_ANGLE;
      end
      ST_ANGLE: begin
        cmd.angle_en = 1'b1;
        cmd.acc_op   = ACC_LD_FUSED;
        cmd.mul_sel  = MUL_G_C01;
        state_nxt    = ST_A1;
      end
      ST_A1: begin
        cmd.acc_op = ACC_ADD_PROD;
        state_nxt  = ST_F1;
      end
      ST_F1: begin
        cmd.fuse_en = 1'b1;
        cmd.mul_sel = MUL_ACC_C02;
        state_nxt   = ST_A2;
      end
      ST_A2: begin
        cmd.acc_op  = ACC_LD_PROD;
        cmd.mul_sel = MUL_FUS_C08;
        state_nxt   = ST_A3;
      end
      ST_A3: begin
        cmd.acc_op = ACC_ADD_PROD;
        state_nxt  = ST_F2;
      end
      ST_F2: begin
        cmd.fuse_en   = 1'b1;
        cmd.target_en = 1'b1;
        state_nxt     = ST_ERR;
      end
      ST_ERR: begin
        cmd.err_en = 1'b1;
        state_nxt  = ST_P4;
      end
      ST_P4: begin
        cmd.mul_sel = MUL_ERR_AG;
        state_nxt   = ST_A4;
      end
      ST_A4: begin
        cmd.acc_op  = ACC_LD_PROD;
        cmd.mul_sel = MUL_G_RG;
        state_nxt   = ST_A5;
      end
      ST_A5: begin
        cmd.acc_op = ACC_ADD_PROD;
        state_nxt  = ST_DRV;
      end
      ST_DRV: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.drive_en = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.drive_en) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/btc_dpath.sv
// Datapath of the balance tilt controller: CORDIC, shared multiplier, accumulator, outputs.
`default_nettype none

module btc_dpath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire btc_pkg::cfg_t      cfg,
  input  wire btc_pkg::dp_cmd_t   cmd,
  output btc_pkg::dp_sts_t        sts,
  input  wire logic signed [15:0] in_accel_y,
  input  wire logic signed [15:0] in_accel_z,
  input  wire logic signed [15:0] in_gyro_rate,
  output logic [15:0]             out_left_forward,
  output logic [15:0]             out_left_reverse,
  output logic [15:0]             out_right_forward,
  output logic [15:0]             out_right_reverse,
  output logic signed [16:0]      out_drive,
  output logic signed [17:0]      out_tilt_angle
);
  import btc_pkg::*;

  localparam int Q_W = ACC_W - 16;

  // frame sample registers
  logic signed [15:0] ay_r, az_r, g_r;

  // CORDIC state
  logic signed [XY_W-1:0] x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [Z_W-1:0]  z_r, z_nxt, tab;
  logic [CIDX_W-1:0]      i_r, i_nxt;

  // frame state
  logic signed [15:0] accel_r;
  logic signed [17:0] fused_r;
  logic signed [16:0] last_drive_r;
  logic signed [13:0] target_r;
  logic signed [18:0] err_r;

  // multiplier and accumulator
  logic signed [18:0]       op_a;
  logic signed [16:0]       op_b;
  logic signed [PROD_W-1:0] prod_w, prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt, prod_ext, accb;
  logic signed [ACC_W-1:0]  accq;
  logic signed [Q_W-1:0]    q;

  // start values
  logic signed [16:0] az_ext, az_mag;

  // angle path
  logic signed [Z_W-1:0] zf, zb, zq;
  logic signed [16:0]    a_div, a_val;
  logic signed [17:0]    sum18, sumb, half;
  logic signed [15:0]    accel_nxt;

  // saturated quotients
  logic signed [17:0] fused_sat;
  logic signed [16:0] drive_sat;

  // setpoint
  logic signed [16:0] lim_s, neg_lim;
  logic signed [13:0] center14, swing14;

  // output path
  logic               drv_pos;
  logic [16:0]        mag;
  logic [17:0]        pwm18;
  logic [15:0]        pwm16;
  logic [15:0]        fwd_r, rev_r;
  logic signed [16:0] drive_out_r;
  logic signed [17:0] tilt_out_r;

  // ---------------- CORDIC ----------------
  assign az_ext = {in_accel_z[15], in_accel_z};
  assign az_mag = az_ext[16] ? -az_ext : az_ext;

  assign dx  = y_r >>> i_r;
  assign dy  = x_r >>> i_r;
  assign tab = $signed({{(Z_W-25){1'b0}}, atan_lut(5'(i_r))});

  assign sts.cord_last = (i_r == CIDX_W'(CORDIC_STEPS - 1));

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    i_nxt = i_r;
    if (cmd.start) begin
      x_nxt = $signed({{(XY_W-25){1'b0}}, az_mag, 8'd0});
      y_nxt = $signed({{(XY_W-24){in_accel_y[15]}}, in_accel_y, 8'd0});
      z_nxt = '0;
      i_nxt = '0;
    end else if (cmd.cord_step) begin
      if (!y_r[XY_W-1]) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + tab;
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - tab;
      end
      i_nxt = i_r + CIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
    if (cmd.start) begin
      ay_r <= in_accel_y;
      az_r <= in_accel_z;
      g_r  <= in_gyro_rate;
    end
  end

  // ---------------- accel angle ----------------
  assign zf    = az_r[15] ? -z_r : z_r;
  assign zb    = zf + (zf[Z_W-1] ? $signed(Z_W'(4095)) : $signed(Z_W'(0)));
  assign zq    = zb >>> 12;
  assign a_div = zq[16:0];

  always_comb begin
    if (az_r == 16'sd0) begin
      if (ay_r == 16'sd0)  a_val = 17'sd0;
      else if (ay_r[15])   a_val = -17'sd9425;
      else                 a_val = 17'sd9425;
    end else if (az_r[15]) begin
      a_val = a_div[16] ? a_div + 17'sd18768 : a_div - 17'sd18768;
    end else begin
      a_val = a_div;
    end
  end

  // average with the previous angle, truncating toward zero
  assign sum18 = {{2{accel_r[15]}}, accel_r} + {a_val[16], a_val};
  assign sumb  = sum18 + {17'd0, sum18[17]};
  assign half  = sumb >>> 1;

  always_comb begin
    if (!half[17] && (half[16:15] != 2'b00))     accel_nxt = 16'sh7FFF;
    else if (half[17] && (half[16:15] != 2'b11)) accel_nxt = -16'sh8000;
    else                                         accel_nxt = half[15:0];
  end

  // ---------------- multiplier ----------------
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_sel)
      MUL_G_C01: begin
        op_a = {{3{g_r[15]}}, g_r};
        op_b = 17'sd6554;
      end
      MUL_ACC_C02: begin
        op_a = {{3{accel_r[15]}}, accel_r};
        op_b = 17'sd13107;
      end
      MUL_FUS_C08: begin
        op_a = {fused_r[17], fused_r};
        op_b = 17'sd52429;
      end
      MUL_ERR_AG: begin
        op_a = err_r;
        op_b = $signed({1'b0, cfg.angle_gain});
      end
      MUL_G_RG: begin
        op_a = {{3{g_r[15]}}, g_r};
        op_b = $signed({1'b0, cfg.rate_gain});
      end
      default: ;
    endcase
  end

  assign prod_w   = op_a * op_b;
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    acc_nxt = acc_r;
    case (cmd.acc_op)
      ACC_LD_FUSED: acc_nxt = {{(ACC_W-34){fused_r[17]}}, fused_r, 16'd0};
      ACC_LD_PROD:  acc_nxt = prod_ext;
      ACC_ADD_PROD: acc_nxt = acc_r + prod_ext;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.mul_sel != MUL_NONE) prod_r <= prod_w;
  end

  // Q16 quotient, truncated toward zero
  assign accb = acc_r + (acc_r[ACC_W-1] ? $signed(ACC_W'(65535)) : $signed(ACC_W'(0)));
  assign accq = accb >>> 16;
  assign q    = accq[Q_W-1:0];

  always_comb begin
    if (q > $signed(Q_W'(131071)))       fused_sat = 18'sh1FFFF;
    else if (q < -$signed(Q_W'(131072))) fused_sat = -18'sh20000;
    else                                 fused_sat = q[17:0];
    if (q > $signed(Q_W'(65535)))        drive_sat = 17'shFFFF;
    else if (q < -$signed(Q_W'(65536)))  drive_sat = -17'sh10000;
    else                                 drive_sat = q[16:0];
  end

  // ---------------- setpoint ----------------
  assign lim_s    = $signed({2'b00, cfg.switch_limit});
  assign neg_lim  = -lim_s;
  assign center14 = $signed({cfg.setpoint_center[12], cfg.setpoint_center});
  assign swing14  = $signed({2'b00, cfg.setpoint_swing});

  // ---------------- drive and PWM ----------------
  assign drv_pos = !drive_sat[16] && (drive_sat != 17'sd0);
  assign mag     = drv_pos ? drive_sat : -drive_sat;
  assign pwm18   = {1'b0, mag} + {6'd0, cfg.pwm_offset};
  assign pwm16   = (pwm18[17:16] != 2'b00) ? 16'hFFFF : pwm18[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r      <= '0;
      fused_r      <= '0;
      last_drive_r <= '0;
      target_r     <= -14'sd300;
    end else begin
      if (cmd.angle_en) accel_r <= accel_nxt;
      if (cmd.fuse_en)  fused_r <= fused_sat;
      if (cmd.drive_en) last_drive_r <= drive_sat;
      if (cfg.center_wr) begin
        target_r <= center14;
      end else if (cmd.target_en) begin
        // shift the setpoint when the previous drive ran past the limit
        if (last_drive_r > lim_s)        target_r <= center14 - swing14;
        else if (last_drive_r < neg_lim) target_r <= center14 + swing14;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_en) err_r <= {fused_r[17], fused_r} - {{5{target_r[13]}}, target_r};
    if (cmd.drive_en) begin
      drive_out_r <= drive_sat;
      tilt_out_r  <= fused_r;
      fwd_r       <= drv_pos ? pwm16 : 16'd0;
      rev_r       <= drv_pos ? 16'd0 : pwm16;
    end
  end

  assign out_left_forward  = fwd_r;
  assign out_right_forward = fwd_r;
  assign out_left_reverse  = rev_r;
  assign out_right_reverse = rev_r;
  assign out_drive         = drive_out_r;
  assign out_tilt_angle    = tilt_out_r;

endmodule

`default_nettype wire

### sv/balance_tilt_controller_top.sv
// An accepted frame runs through the one-step-per-cycle CORDIC, then the single shared
// multiplier; no new frame is taken until the last one is done. A result waiting in
// the output register stalls the next frame only at its final step. Reset (synchronous,
// rst_n low) clears the angle state and the last drive, loads the configuration defaults
// and a setpoint of -300, and drops out_valid.
`default_nettype none

module balance_tilt_controller_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_accel_y,
  input  wire logic signed [15:0] in_accel_z,
  input  wire logic signed [15:0] in_gyro_rate,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_left_forward,
  output logic [15:0]             out_left_reverse,
  output logic [15:0]             out_right_forward,
  output logic [15:0]             out_right_reverse,
  output logic signed [16:0]      out_drive,
  output logic signed [17:0]      out_tilt_angle,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata
);
  import btc_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  btc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  btc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  btc_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cmd               (cmd),
    .sts               (sts),
    .in_accel_y        (in_accel_y),
    .in_accel_z        (in_accel_z),
    .in_gyro_rate      (in_gyro_rate),
    .out_left_forward  (out_left_forward),
    .out_left_reverse  (out_left_reverse),
    .out_right_forward (out_right_forward),
    .out_right_reverse (out_right_reverse),
    .out_drive         (out_drive),
    .out_tilt_angle    (out_tilt_angle)
  );

endmodule

`default_nettype wire

### sv/btc_checker.sv
// Port-level checker for the balance tilt controller, bound to the top level.
`default_nettype none

module btc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [15:0]        out_left_forward,
  input wire logic [15:0]        out_left_reverse,
  input wire logic [15:0]        out_right_forward,
  input wire logic [15:0]        out_right_reverse,
  input wire logic signed [16:0] out_drive
);

  // a result beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before the beat was taken");

  // a frame keeps the block busy: no second beat right after one is taken
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an input beat");

  // positive drive uses the forward channels of both motors only
  a_fwd_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_drive[16] && (out_drive != 17'sd0) |->
      (out_left_reverse == 16'd0) && (out_right_reverse == 16'd0) &&
      (out_left_forward == out_right_forward))
    else $error("forward drive with wrong PWM channels");

  // zero or negative drive uses the reverse channels only
  a_rev_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_drive[16] || (out_drive == 17'sd0)) |->
      (out_left_forward == 16'd0) && (out_right_forward == 16'd0) &&
      (out_left_reverse == out_right_reverse))
    else $error("reverse drive with wrong PWM channels");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind balance_tilt_controller_top btc_checker u_btc_checker (.*);

`default_nettype wire

### tb/sv/balance_tilt_controller_top_test.sv
// Self-checking testbench for balance_tilt_controller_top: scoreboard, stimulus and handshakes.
module balance_tilt_controller_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import btc_pkg::*;

  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam int SETTLE_CYCLES = CORDIC_STEPS + 16;
  localparam int DRAIN_LIMIT   = 100000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_FRAMES  = 210;

  localparam longint Q16_ONE         = 65536;
  localparam longint Q16_TENTH       = 6554;
  localparam longint Q16_FIFTH       = 13107;
  localparam longint Q16_FOUR_FIFTHS = 52429;
  localparam longint HALF_TURN       = 18768;
  localparam longint RIGHT_ANGLE     = 9425;
  localparam longint ATAN_SCALE      = 4096;

  typedef struct packed {
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_rate;
  } frame_t;

  typedef struct packed {
    logic [15:0]        left_forward;
    logic [15:0]        left_reverse;
    logic [15:0]        right_forward;
    logic [15:0]        right_reverse;
    logic signed [16:0] drive;
    logic signed [17:0] tilt_angle;
  } motor_cmd_t;

  typedef struct packed {
    logic [11:0]        pwm_offset;
    logic signed [12:0] setpoint_center;
    logic [11:0]        setpoint_swing;
    logic [14:0]        switch_limit;
    logic [15:0]        angle_gain;
    logic [15:0]        rate_gain;
  } reg_setting_t;

  class motor_cmd_scoreboard;
    motor_cmd_t expected_cmds[$];
    int errors;
    int checked;
    int frames;
    longint pwm_offset, center, swing, limit, angle_gain, rate_gain;
    longint accel_angle, fused_angle, last_drive, target_angle;

    function new();
      pwm_offset   = 360;
      center       = -300;
      swing        = 800;
      limit        = 500;
      angle_gain   = 26214;
      rate_gain    = 36045;
      accel_angle  = 0;
      fused_angle  = 0;
      last_drive   = 0;
      target_angle = -300;
      errors       = 0;
      checked      = 0;
      frames       = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] value);
      case (idx)
        REG_PWM_OFFSET: pwm_offset = value[11:0];
        REG_SETPOINT_CENTER: begin
          center       = longint'($signed(value[12:0]));
          target_angle = center;
        end
        REG_SETPOINT_SWING: swing = value[11:0];
        REG_SWITCH_LIMIT:   limit = value[14:0];
        REG_ANGLE_GAIN:     angle_gain = value;
        REG_RATE_GAIN:      rate_gain = value;
        default: ;
      endcase
    endfunction

    static function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // atan(2^-i) in 1/(6000*4096) rad
    static function longint atan_step(int i);
      case (i)
        0:  return 19301945;
        1:  return 11394604;
        2:  return 6020596;
        3:  return 3056148;
        4:  return 1534005;
        5:  return 767750;
        6:  return 383969;
        7:  return 191996;
        8:  return 96000;
        9:  return 48000;
        10: return 24000;
        11: return 12000;
        12: return 6000;
        13: return 3000;
        14: return 1500;
        15: return 750;
        16: return 375;
        17: return 187;
        18: return 94;
        19: return 47;
        20: return 23;
        21: return 12;
        22: return 6;
        23: return 3;
        default: return 0;
      endcase
    endfunction

    function longint accel_tilt(longint ay, longint az);
      longint x, y, z, dx, dy, a;
      if (az == 0) return (ay > 0) ? RIGHT_ANGLE : ((ay < 0) ? -RIGHT_ANGLE : 0);
      x = ((az < 0) ? -az : az) * 256;
      y = ay * 256;
      z = 0;
      // vectoring mode: drive y to zero, floor shifts
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx;
          y -= dy;
          z += atan_step(i);
        end else begin
          x -= dx;
          y += dy;
          z -= atan_step(i);
        end
      end
      if (az < 0) z = -z;
      a = z / ATAN_SCALE;
      if (az < 0) a = (a < 0) ? a + HALF_TURN : a - HALF_TURN;
      return a;
    endfunction

    function void note_frame(frame_t f);
      longint ay, az, g, t, drive;
      motor_cmd_t cmd;
      ay = $signed(f.accel_y);
      az = $signed(f.accel_z);
      g  = $signed(f.gyro_rate);

      accel_angle = clamp((accel_angle + accel_tilt(ay, az)) / 2, -32768, 32767);
      t = fused_angle * Q16_ONE + g * Q16_TENTH;
      fused_angle = clamp(t / Q16_ONE, -131072, 131071);
      t = accel_angle * Q16_FIFTH + fused_angle * Q16_FOUR_FIFTHS;
      fused_angle = clamp(t / Q16_ONE, -131072, 131071);

      // switch the setpoint on the previous drive, before the new one
      if (last_drive > limit) target_angle = center - swing;
      else if (last_drive < -limit) target_angle = center + swing;

      t = (fused_angle - target_angle) * angle_gain + g * rate_gain;
      drive = clamp(t / Q16_ONE, -65536, 65535);
      last_drive = drive;

      cmd = '0;
      if (drive > 0) begin
        cmd.left_forward  = 16'(clamp(drive + pwm_offset, 0, 65535));
        cmd.right_forward = cmd.left_forward;
      end else begin
        cmd.left_reverse  = 16'(clamp(-drive + pwm_offset, 0, 65535));
        cmd.right_reverse = cmd.left_reverse;
      end
      cmd.drive      = 17'(drive);
      cmd.tilt_angle = 18'(fused_angle);
      expected_cmds.push_back(cmd);
      frames++;
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_cmd(motor_cmd_t got);
      motor_cmd_t want;
      if (expected_cmds.size() == 0) begin
        $error("motor command beat with no frame pending");
        errors++;
        return;
      end
      want = expected_cmds.pop_front();
      checked++;
      compare_field("left_forward", want.left_forward, got.left_forward);
      compare_field("left_reverse", want.left_reverse, got.left_reverse);
      compare_field("right_forward", want.right_forward, got.right_forward);
      compare_field("right_reverse", want.right_reverse, got.right_reverse);
      compare_field("drive", $signed(want.drive), $signed(got.drive));
      compare_field("tilt_angle", $signed(want.tilt_angle), $signed(got.tilt_angle));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [15:0]  in_accel_y = '0;
  logic signed [15:0]  in_accel_z = '0;
  logic signed [15:0]  in_gyro_rate = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [15:0]         out_left_forward;
  logic [15:0]         out_left_reverse;
  logic [15:0]         out_right_forward;
  logic [15:0]         out_right_reverse;
  logic signed [16:0]  out_drive;
  logic signed [17:0]  out_tilt_angle;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [15:0]         cfg_wdata = '0;

  motor_cmd_scoreboard sb;
  int settings_loaded = 0;

  balance_tilt_controller_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_accel_y       (in_accel_y),
    .in_accel_z       (in_accel_z),
    .in_gyro_rate     (in_gyro_rate),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_forward (out_left_forward),
    .out_left_reverse (out_left_reverse),
    .out_right_forward(out_right_forward),
    .out_right_reverse(out_right_reverse),
    .out_drive        (out_drive),
    .out_tilt_angle   (out_tilt_angle),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $error("run did not complete in time");
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stalls, with calm stretches of steady ready
  initial begin : out_ready_pattern
    int hold;
    int cycle;
    bit calm;
    hold  = 0;
    cycle = 0;
    calm  = 1'b0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle % 400 == 0) calm = ($urandom_range(0, 2) == 0);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) hold = $urandom_range(1, 25);
      end
    end
  end

  // sample at negedge: values hold until the next rising edge
  always @(negedge clk) begin : cmd_monitor
    motor_cmd_t got;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      got.left_forward  = out_left_forward;
      got.left_reverse  = out_left_reverse;
      got.right_forward = out_right_forward;
      got.right_reverse = out_right_reverse;
      got.drive         = out_drive;
      got.tilt_angle    = out_tilt_angle;
      sb.check_cmd(got);
    end
  end

  function automatic frame_t frame_of(int ay, int az, int g);
    frame_t f;
    f.accel_y   = 16'(ay);
    f.accel_z   = 16'(az);
    f.gyro_rate = 16'(g);
    return f;
  endfunction

  function automatic logic signed [15:0] corner_value();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return -16'sd1;
      2: return 16'sd0;
      3: return 16'sd1;
      4: return 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      // near upright: gravity mostly on z, small tilt and rate
      f.accel_z = 16'(int'($urandom_range(11000, 21000)));
      if ($urandom_range(0, 9) == 0) f.accel_z = -f.accel_z;
      f.accel_y   = 16'(int'($urandom_range(0, 16000)) - 8000);
      f.gyro_rate = 16'(int'($urandom_range(0, 8000)) - 4000);
    end else if (kind < 75) begin
      f.accel_y   = corner_value();
      f.accel_z   = corner_value();
      f.gyro_rate = corner_value();
    end else begin
      f.accel_y   = 16'($urandom);
      f.accel_z   = 16'($urandom);
      f.gyro_rate = 16'($urandom);
    end
    return f;
  endfunction

  function automatic longint biased(longint hi);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return hi;
      default: return longint'($urandom_range(0, hi));
    endcase
  endfunction

  function automatic reg_setting_t random_setting();
    reg_setting_t s;
    s.pwm_offset = 12'(biased(4095));
    case ($urandom_range(0, 3))
      0: s.setpoint_center = -13'sd4096;
      1: s.setpoint_center = 13'sd4095;
      default: s.setpoint_center = 13'(int'($urandom_range(0, 8191)) - 4096);
    endcase
    s.setpoint_swing = 12'(biased(4095));
    // keep the limit low most of the time so the setpoint keeps switching
    if ($urandom_range(0, 1) == 0) s.switch_limit = 15'($urandom_range(0, 1500));
    else s.switch_limit = 15'(biased(32767));
    s.angle_gain = 16'(biased(65535));
    s.rate_gain  = 16'(biased(65535));
    return s;
  endfunction

  function automatic reg_setting_t edge_setting(bit top);
    reg_setting_t s;
    s.pwm_offset      = top ? 12'hfff : 12'h000;
    s.setpoint_center = top ? 13'sd4095 : -13'sd4096;
    s.setpoint_swing  = top ? 12'hfff : 12'h000;
    s.switch_limit    = top ? 15'h7fff : 15'h0000;
    s.angle_gain      = top ? 16'hffff : 16'h0000;
    s.rate_gain       = top ? 16'hffff : 16'h0000;
    return s;
  endfunction

  task automatic put_reg(logic [2:0] idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic load_settings(reg_setting_t s);
    put_reg(REG_PWM_OFFSET, {4'b0000, s.pwm_offset});
    put_reg(REG_SETPOINT_CENTER, {3'b000, s.setpoint_center});
    put_reg(REG_SETPOINT_SWING, {4'b0000, s.setpoint_swing});
    put_reg(REG_SWITCH_LIMIT, {1'b0, s.switch_limit});
    put_reg(REG_ANGLE_GAIN, s.angle_gain);
    put_reg(REG_RATE_GAIN, s.rate_gain);
    // unmapped indexes must leave every register alone
    put_reg(REG_SPARE_LO, 16'($urandom));
    put_reg(REG_SPARE_HI, 16'($urandom));
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // call at a rising edge; returns at the edge that took the beat, valid still high
  task automatic send_frame(frame_t f);
    bit taken;
    in_valid     <= 1'b1;
    in_accel_y   <= f.accel_y;
    in_accel_z   <= f.accel_z;
    in_gyro_rate <= f.gyro_rate;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (in_ready === 1'b1);
      @(posedge clk);
    end
    sb.note_frame(f);
  endtask

  task automatic wait_for_cmds();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (sb.expected_cmds.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic stream_frames(int count);
    int sent, burst, gap;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
      for (int b = 0; b < burst && sent < count; b++) begin
        send_frame(random_frame());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: angle corners
    send_frame(frame_of(0, 0, 0));
    send_frame(frame_of(100, 0, 0));
    send_frame(frame_of(-100, 0, 0));
    send_frame(frame_of(0, -16384, 0));
    send_frame(frame_of(5000, -16384, 0));
    send_frame(frame_of(-5000, -16384, 0));
    send_frame(frame_of(32767, 32767, 32767));
    send_frame(frame_of(-32768, -32768, -32768));
    send_frame(frame_of(-32768, 32767, 0));
    send_frame(frame_of(32767, -32768, 0));
    send_frame(frame_of(1, 1, 1));
    send_frame(frame_of(-1, -1, -1));
    // push the drive past the limit both ways to flip the setpoint
    send_frame(frame_of(0, 16384, 32767));
    send_frame(frame_of(0, 16384, 32767));
    send_frame(frame_of(0, 16384, -32768));
    send_frame(frame_of(0, 16384, -32768));
    wait_for_cmds();

    // zero gains: drive stays at zero and takes the reverse channels
    load_settings(edge_setting(1'b0));
    send_frame(frame_of(1000, 16384, 500));
    send_frame(frame_of(-1000, 16384, -500));
    wait_for_cmds();

    // full gains and offset: PWM saturation in both directions
    load_settings(edge_setting(1'b1));
    send_frame(frame_of(32767, 1, 32767));
    send_frame(frame_of(32767, 1, 32767));
    send_frame(frame_of(32767, 1, 32767));
    send_frame(frame_of(-32768, 1, -32768));
    send_frame(frame_of(-32768, 1, -32768));
    send_frame(frame_of(-32768, 1, -32768));
    wait_for_cmds();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) load_settings(edge_setting(1'b1));
      else if (p == 1) load_settings(edge_setting(1'b0));
      else load_settings(random_setting());
      stream_frames(PHASE_FRAMES);
      wait_for_cmds();
    end

    if (sb.expected_cmds.size() != 0) begin
      $error("%0d motor commands never arrived", sb.expected_cmds.size());
      sb.errors++;
    end
    $display("Run covered %0d sensor frames and %0d checked motor commands over %0d register loads,",
             sb.frames, sb.checked, settings_loaded);
    $display("with angle corners, setpoint flips, PWM saturation, sender gaps and receiver stalls.");
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
